### design/olad_pkg.sv
// Package for the ordered list block: sizes, operation and status codes,
// and the sequencer state type. No dependencies.
`default_nettype none

package olad_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int FUNC_W   = 2;
	localparam int STAT_W   = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND = 2'd0,
		FN_DELETE = 2'd1,
		FN_LIST   = 2'd2
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_APPENDED = 3'd0,
		ST_DELETED  = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_LISTED   = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_SHIFT,
		S_LIST,
		S_RESP
	} state_t;

endpackage

`default_nettype wire

### design/olad_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Self-contained, no package use.
`default_nettype none

module olad_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                        wr_data,
	input  wire logic                                    rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### design/ordered_list_append_delete_top.sv
// Ordered list with append, delete-first-match and list operations.
// Depends on olad_pkg and olad_ram.
//
//  Channel | Dir | Handshake        | Payload
//  --------+-----+------------------+--------------------------------------------
//  s_*     | in  | s_tvalid/s_tready| s_tuser: func; s_tdata: value
//  m_*     | out | m_tvalid/m_tready| m_tuser: status; m_tdata: entry_value;
//          |     |                  | m_tlast: last
//
// Per transaction: append, and any empty or full answer, pass from acceptance
// through the start state to the response state. A delete does one read per
// cycle while scanning, then one read and one write per cycle while closing the
// gap. A list of n entries streams n results, one per cycle while the output
// register is not stalled. The single read port of the entry RAM sets this pace;
// the block works on one transaction at a time. Reset clears the entry count and
// the output valid; entry contents are not cleared. A stall on m_tready holds the
// sequencer in its list and response states, and the RAM read data, until the
// output register frees.
`default_nettype none

module ordered_list_append_delete_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [olad_pkg::DATA_W-1:0]  s_tdata,  // [31:0] value
	input  wire logic [olad_pkg::FUNC_W-1:0]  s_tuser,  // [1:0] func
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic      [olad_pkg::DATA_W-1:0]  m_tdata,  // [31:0] entry_value
	output logic      [olad_pkg::STAT_W-1:0]  m_tuser,  // [2:0] status
	output logic                              m_tlast   // last
);

	localparam int CNT_W = olad_pkg::CNT_W;
	localparam int IDX_W = olad_pkg::IDX_W;
	localparam int DATA_W = olad_pkg::DATA_W;

	// Sequencer and list state
	olad_pkg::state_t  state_q, state_d;
	olad_pkg::func_t   op_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	olad_pkg::status_t rsp_status_q, rsp_status_d;
	logic [DATA_W-1:0] rsp_value_q, rsp_value_d;

	// Output register
	logic              m_tvalid_q;
	olad_pkg::status_t out_status_q, out_status_d;
	logic [DATA_W-1:0] out_value_q, out_value_d;
	logic              out_last_q, out_last_d;
	logic              out_load;
	logic              out_free;

	// RAM port
	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;

	// Walk helpers
	logic [CNT_W-1:0]  idx_p1;
	logic [CNT_W:0]    idx_p2;
	logic              at_last;
	logic              shift_done;
	logic              hit;
	logic              is_full;
	logic              is_empty;

	olad_ram #(
		.WIDTH (DATA_W),
		.DEPTH (olad_pkg::CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign s_tready = (state_q == olad_pkg::S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	assign idx_p1     = CNT_W'(idx_q) + CNT_W'(1);
	assign idx_p2     = (CNT_W+1)'(idx_q) + (CNT_W+1)'(2);
	assign at_last    = (idx_p1 == count_q);
	assign shift_done = (idx_p2 == {1'b0, count_q});
	assign hit        = (ram_rdata == val_q);
	assign is_full    = (count_q == CNT_W'(olad_pkg::CAPACITY));
	assign is_empty   = (count_q == '0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			olad_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = olad_pkg::S_START;
				end
			end
			olad_pkg::S_START: begin
				case (op_q)
					olad_pkg::FN_APPEND: state_d = olad_pkg::S_RESP;
					olad_pkg::FN_DELETE: state_d = is_empty ? olad_pkg::S_RESP : olad_pkg::S_SCAN;
					olad_pkg::FN_LIST:   state_d = is_empty ? olad_pkg::S_RESP : olad_pkg::S_LIST;
					default:             state_d = olad_pkg::S_IDLE;
				endcase
			end
			olad_pkg::S_SCAN: begin
				if (hit) begin
					state_d = at_last ? olad_pkg::S_RESP : olad_pkg::S_SHIFT;
				end else if (at_last) begin
					state_d = olad_pkg::S_RESP;
				end
			end
			olad_pkg::S_SHIFT: begin
				if (shift_done) begin
					state_d = olad_pkg::S_RESP;
				end
			end
			olad_pkg::S_LIST: begin
				if (out_free && at_last) begin
					state_d = olad_pkg::S_IDLE;
				end
			end
			olad_pkg::S_RESP: begin
				if (out_free) begin
					state_d = olad_pkg::S_IDLE;
				end
			end
			default: state_d = olad_pkg::S_IDLE;
		endcase
	end

	// Datapath control. The only overlapping accesses are in the gap-closing
	// walk, which writes entry j while reading entry j+2, so no forwarding is
	// needed.
	always_comb begin
		ram_we       = 1'b0;
		ram_waddr    = idx_q;
		ram_wdata    = ram_rdata;
		ram_re       = 1'b0;
		ram_raddr    = '0;
		count_d      = count_q;
		idx_d        = idx_q;
		rsp_status_d = rsp_status_q;
		rsp_value_d  = rsp_value_q;
		out_load     = 1'b0;
		out_status_d = olad_pkg::ST_LISTED;
		out_value_d  = ram_rdata;
		out_last_d   = 1'b1;
		case (state_q)
			olad_pkg::S_START: begin
				rsp_value_d = val_q;
				case (op_q)
					olad_pkg::FN_APPEND: begin
						if (is_full) begin
							rsp_status_d = olad_pkg::ST_FULL;
						end else begin
							// write the new tail
							ram_we       = 1'b1;
							ram_waddr    = count_q[IDX_W-1:0];
							ram_wdata    = val_q;
							count_d      = count_q + CNT_W'(1);
							rsp_status_d = olad_pkg::ST_APPENDED;
						end
					end
					olad_pkg::FN_DELETE: begin
						rsp_status_d = olad_pkg::ST_EMPTY;
						ram_re       = !is_empty;
						idx_d        = '0;
					end
					olad_pkg::FN_LIST: begin
						rsp_status_d = olad_pkg::ST_EMPTY;
						rsp_value_d  = '0;
						ram_re       = !is_empty;
						idx_d        = '0;
					end
					default: begin
					end
				endcase
			end
			olad_pkg::S_SCAN: begin
				if (hit) begin
					rsp_status_d = olad_pkg::ST_DELETED;
					if (at_last) begin
						count_d = count_q - CNT_W'(1);
					end else begin
						// fetch the successor; idx stays at the hole
						ram_re    = 1'b1;
						ram_raddr = idx_p1[IDX_W-1:0];
					end
				end else if (at_last) begin
					rsp_status_d = olad_pkg::ST_NOTFOUND;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = idx_p1[IDX_W-1:0];
					idx_d     = idx_p1[IDX_W-1:0];
				end
			end
			olad_pkg::S_SHIFT: begin
				// move entry j+1 down into j
				ram_we = 1'b1;
				if (shift_done) begin
					count_d = count_q - CNT_W'(1);
				end else begin
					ram_re    = 1'b1;
					ram_raddr = idx_p2[IDX_W-1:0];
					idx_d     = idx_p1[IDX_W-1:0];
				end
			end
			olad_pkg::S_LIST: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_last_d = at_last;
					if (!at_last) begin
						ram_re    = 1'b1;
						ram_raddr = idx_p1[IDX_W-1:0];
						idx_d     = idx_p1[IDX_W-1:0];
					end
				end
			end
			olad_pkg::S_RESP: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_status_d = rsp_status_q;
					out_value_d  = rsp_value_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= olad_pkg::S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= olad_pkg::func_t'(s_tuser);
			val_q <= s_tdata;
		end
		idx_q        <= idx_d;
		rsp_status_q <= rsp_status_d;
		rsp_value_q  <= rsp_value_d;
		if (out_load) begin
			out_status_q <= out_status_d;
			out_value_q  <= out_value_d;
			out_last_q   <= out_last_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(olad_pkg::CAPACITY))
		else $error("entry count beyond capacity");

	a_port_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("RAM read and write hit the same entry");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == olad_pkg::S_START && op_q == olad_pkg::FN_APPEND && !is_full)
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("append did not grow the list");

	a_list_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == olad_pkg::S_LIST && out_load && out_last_d)
		|=> (state_q == olad_pkg::S_IDLE && m_tvalid_q))
		else $error("list walk did not end on its last entry");

	a_no_load_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

### dv/olad_checker.sv
// Checker for the ordered list block: watches both stream channels, keeps its own
// copy of the list, predicts every result and compares it field by field.
// Depends on olad_pkg.
module olad_checker
	import olad_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
	input  logic [FUNC_W-1:0] s_tuser,   // [1:0] func
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DATA_W-1:0] m_tdata,   // [31:0] entry_value
	input  logic [STAT_W-1:0] m_tuser,   // [2:0] status
	input  logic              m_tlast,
	output int                fail_count,
	output int                pending,
	output int                ops_seen,
	output int                results_seen,
	output int                peak_fill
);

	typedef struct {
		status_t           st;
		logic [DATA_W-1:0] val;
		logic              last;
	} list_result_t;

	logic [DATA_W-1:0] shadow [CAPACITY];
	int                fill;
	list_result_t      awaited [$];

	initial begin
		fill         = 0;
		fail_count   = 0;
		pending      = 0;
		ops_seen     = 0;
		results_seen = 0;
		peak_fill    = 0;
	end

	function automatic void push_result(input status_t st, input logic [DATA_W-1:0] v,
			input logic l);
		list_result_t r;
		r.st   = st;
		r.val  = v;
		r.last = l;
		awaited.push_back(r);
	endfunction

	// Apply one operation to the shadow list and queue the results it causes.
	function automatic void predict_op(input logic [FUNC_W-1:0] fn,
			input logic [DATA_W-1:0] v);
		int hit;
		int i;
		int j;
		hit = -1;
		case (fn)
		FN_APPEND: begin
			if (fill >= CAPACITY) begin
				push_result(ST_FULL, v, 1'b1);
			end else begin
				shadow[fill] = v;
				fill++;
				push_result(ST_APPENDED, v, 1'b1);
			end
		end
		FN_DELETE: begin
			if (fill == 0) begin
				push_result(ST_EMPTY, v, 1'b1);
			end else begin
				for (i = 0; i < fill; i++)
					if (hit < 0 && shadow[i] == v)
						hit = i;
				if (hit < 0) begin
					push_result(ST_NOTFOUND, v, 1'b1);
				end else begin
					// close the gap, keep the order of the rest
					for (j = hit; j + 1 < fill; j++)
						shadow[j] = shadow[j + 1];
					fill--;
					push_result(ST_DELETED, v, 1'b1);
				end
			end
		end
		FN_LIST: begin
			if (fill == 0)
				push_result(ST_EMPTY, '0, 1'b1);
			else
				for (i = 0; i < fill; i++)
					push_result(ST_LISTED, shadow[i], (i + 1 == fill));
		end
		default: ;  // unused code: no state change, no result
		endcase
	endfunction

	always @(posedge clk) begin : watch
		list_result_t want;
		if (arst_n) begin
			// results first: an output can never stem from an input taken at the same edge
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (awaited.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result: expected none, got status %0d value %h last %b",
						$time, m_tuser, m_tdata, m_tlast);
				end else begin
					want = awaited.pop_front();
					if (m_tuser !== want.st) begin
						fail_count++;
						$display("%0t: status mismatch: expected %0d, got %0d",
							$time, want.st, m_tuser);
					end
					if (m_tdata !== want.val) begin
						fail_count++;
						$display("%0t: entry_value mismatch: expected %h, got %h",
							$time, want.val, m_tdata);
					end
					if (m_tlast !== want.last) begin
						fail_count++;
						$display("%0t: last mismatch: expected %b, got %b",
							$time, want.last, m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				ops_seen++;
				predict_op(s_tuser, s_tdata);
				if (fill > peak_fill)
					peak_fill = fill;
			end
			pending = awaited.size();
		end
	end

endmodule

### dv/tb_top.sv
// Testbench top for the ordered list block: clock, reset, stimulus on the input
// stream, back-pressure on the output stream, and the final verdict.
// Depends on olad_pkg, ordered_list_append_delete_top and olad_checker.
module tb_top;
	import olad_pkg::*;

	// func code the block must ignore
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIX
	} phase_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;   // [31:0] value
	logic [FUNC_W-1:0] s_tuser;   // [1:0] func
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;   // [31:0] entry_value
	logic [STAT_W-1:0] m_tuser;   // [2:0] status
	logic              m_tlast;

	int fail_count;
	int pending;
	int ops_seen;
	int results_seen;
	int peak_fill;

	// pacing knobs shared by the two traffic processes
	bit tx_calm  = 1'b0;  // sender offers back to back
	bit rx_calm  = 1'b0;  // receiver always ready
	bit hold_req = 1'b0;  // ask the receiver for one long hold-off

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ordered_list_append_delete_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	olad_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.fail_count   (fail_count),
		.pending      (pending),
		.ops_seen     (ops_seen),
		.results_seen (results_seen),
		.peak_fill    (peak_fill)
	);

	// Values come mostly from a small pool so that deletes find matches and
	// duplicates pile up; the extremes and full-width random words keep every
	// bit of the value toggling.
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
		0:       return 32'h8000_0000;
		1:       return 32'h7fff_ffff;
		2, 3:    return $urandom();
		default: return 32'($urandom_range(0, 11)) - 32'd6;
		endcase
	endfunction

	// Offer one transaction after a random gap and hold it until it is taken.
	// Return at the accepting edge so the next call can keep tvalid high.
	task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] v);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
	endtask

	// Draw one operation, biased by the phase; report whether it counts
	// (the unused code is merely dropped by the block).
	task automatic send_random(input phase_t mode, output bit counted);
		int r;
		int app_lim;
		int del_lim;
		r = $urandom_range(0, 99);
		case (mode)
		MODE_FILL: begin
			app_lim = 75;
			del_lim = 90;
		end
		MODE_DRAIN: begin
			app_lim = 15;
			del_lim = 82;
		end
		default: begin
			app_lim = 40;
			del_lim = 76;
		end
		endcase
		counted = 1'b1;
		if (r < app_lim) begin
			send_op(FN_APPEND, pick_value());
		end else if (r < del_lim) begin
			send_op(FN_DELETE, pick_value());
		end else if (r < 97) begin
			send_op(FN_LIST, pick_value());
		end else begin
			send_op(FN_UNUSED, pick_value());
			counted = 1'b0;
		end
	endtask

	// Receiver: stall a random number of cycles before each result, with calm
	// stretches of plain readiness, and one long hold-off on request.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				stall = 300;
			end else begin
				stall = rx_calm ? 0 : $urandom_range(0, 11);
			end
			if ($urandom_range(0, 49) == 0)
				rx_calm = !rx_calm;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Stimulus and verdict.
	initial begin
		phase_t mode;
		int     phase_left;
		int     counted_ops;
		bit     counted;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = FN_APPEND;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty-list answers and the dropped code
		send_op(FN_LIST,   32'hdead_beef);
		send_op(FN_DELETE, 32'h8000_0000);
		send_op(FN_UNUSED, 32'h0000_1234);
		// extremes, with a duplicate to check first-match delete
		send_op(FN_APPEND, 32'h8000_0000);
		send_op(FN_APPEND, 32'h7fff_ffff);
		send_op(FN_APPEND, 32'h0000_0000);
		send_op(FN_APPEND, 32'hffff_ffff);
		send_op(FN_APPEND, 32'h7fff_ffff);
		send_op(FN_LIST,   32'h0000_0000);
		send_op(FN_DELETE, 32'h7fff_ffff);  // first copy, not the tail one
		send_op(FN_DELETE, 32'h5555_5555);  // no match
		send_op(FN_DELETE, 32'h8000_0000);  // head
		send_op(FN_DELETE, 32'h7fff_ffff);  // tail
		send_op(FN_LIST,   32'hffff_ffff);
		send_op(FN_DELETE, 32'h0000_0000);
		send_op(FN_DELETE, 32'hffff_ffff);  // list now empty again
		send_op(FN_LIST,   32'h1234_5678);
		send_op(FN_APPEND, 32'haaaa_aaaa);
		send_op(FN_APPEND, 32'h5555_5555);

		// Fill to capacity against a stalled receiver: the block backs up and
		// drops s_tready while the sender keeps offering; then hit the full case.
		hold_req = 1'b1;
		tx_calm  = 1'b1;
		repeat (CAPACITY - 2)
			send_op(FN_APPEND, $urandom());
		send_op(FN_APPEND, 32'h8000_0000);
		send_op(FN_APPEND, 32'h7fff_ffff);
		send_op(FN_LIST,   32'h0000_0000);
		send_op(FN_DELETE, 32'h1357_9bdf);
		tx_calm = 1'b0;

		// random phases: fill-heavy, drain-heavy and mixed traffic
		counted_ops = 0;
		phase_left  = 0;
		mode        = MODE_MIX;
		while (counted_ops < 440) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 60);
				mode       = phase_t'($urandom_range(0, 2));
				tx_calm    = ($urandom_range(0, 3) == 0);
			end
			send_random(mode, counted);
			if (counted)
				counted_ops++;
			phase_left--;
		end
		s_tvalid <= 1'b0;

		// drain the outstanding results, then watch for stray output
		@(posedge clk);
		wait (pending == 0);
		repeat (40) @(posedge clk);

		$display("run covered %0d transactions in, %0d results checked", ops_seen,
			results_seen);
		$display("list peaked at %0d of %0d entries", peak_fill, CAPACITY);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
design/olad_pkg.sv
design/olad_ram.sv
design/ordered_list_append_delete_top.sv
dv/olad_checker.sv
dv/tb_top.sv
